// File: rtl/jeu_pkg.sv
// jeu_pkg: shared types, constants and byte classification for the json escape filter
// used by jeu_front, jeu_queue and jeu_back; no dependencies
package jeu_pkg;

  localparam int POSITION_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_POSITION  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_CAPACITY = 1'd1;
  localparam logic [CFG_DATA_BITS-1:0] START_RESET = 16'h0000;
  localparam logic [CFG_DATA_BITS-1:0] CAP_RESET   = 16'hFFFF;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // slots of the working byte window (held bytes plus one new byte)
  localparam int WIN_SLOTS = 4;

  // character codes
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  typedef enum logic [2:0] {
    K_PASS,
    K_QMARK,
    K_ESC,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       cont;
  } byte_t;

  typedef struct packed {
    byte_t b;
    logic  has;
    logic  fin;
  } item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

  function automatic byte_t classify(input logic [7:0] v);
    byte_t r;
    r.data = v;
    r.cont = (v >= CONT_LO) && (v <= CONT_HI);
    if (v == CH_QUOTE || v == CH_BSLASH || v == CH_LF || v == CH_CR || v == CH_TAB) begin
      r.kind = K_ESC;
    end else if (v < CTRL_LIMIT) begin
      r.kind = K_QMARK;
    end else if (v < ASCII_LIMIT) begin
      r.kind = K_PASS;
    end else if (v >= LEAD2_LO && v <= LEAD2_HI) begin
      r.kind = K_LEAD2;
    end else if (v >= LEAD3_LO && v <= LEAD3_HI) begin
      r.kind = K_LEAD3;
    end else if (v >= LEAD4_LO && v <= LEAD4_HI) begin
      r.kind = K_LEAD4;
    end else begin
      r.kind = K_QMARK;
    end
    return r;
  endfunction

  // second byte of a backslash escape
  function automatic logic [7:0] esc_char(input logic [7:0] v);
    logic [7:0] r;
    if (v == CH_LF) begin
      r = CH_LOW_N;
    end else if (v == CH_CR) begin
      r = CH_LOW_R;
    end else if (v == CH_TAB) begin
      r = CH_LOW_T;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/jeu_front.sv
// jeu_front: input side, accepts stream items and classifies the data byte
// depends on jeu_pkg; feeds jeu_queue
module jeu_front (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // in_byte
  input  logic               s_axis_tuser,   // has_byte
  input  logic               s_axis_tlast,   // is_final
  input  jeu_pkg::qstat_t    stat,
  output logic               push,
  output jeu_pkg::item_t     push_item
);

  assign s_axis_tready = !stat.full;
  assign push          = s_axis_tvalid && !stat.full;

  always_comb begin
    push_item.b   = jeu_pkg::classify(s_axis_tdata);
    push_item.has = s_axis_tuser;
    push_item.fin = s_axis_tlast;
  end

endmodule

// File: rtl/jeu_queue.sv
// jeu_queue: short fifo of classified items between front and back
// depends on jeu_pkg
module jeu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jeu_pkg::item_t   push_item,
  input  logic             pop,
  output jeu_pkg::item_t   head,
  output jeu_pkg::qstat_t  stat
);

  localparam int PB = jeu_pkg::QUEUE_PTR_BITS;

  jeu_pkg::item_t mem [jeu_pkg::QUEUE_DEPTH];
  logic [PB-1:0]  wr_ptr;
  logic [PB-1:0]  rd_ptr;
  logic [PB:0]    count;

  assign head          = mem[rd_ptr];
  assign stat.full     = (count == (PB+1)'(jeu_pkg::QUEUE_DEPTH));
  assign stat.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(jeu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(jeu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PB'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PB+1)'(1);
        2'b01:   count <= count - (PB+1)'(1);
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/jeu_back.sv
// jeu_back: escaper, one byte per cycle unless stalled, utf-8 checks and capacity stop
// depends on jeu_pkg; takes items from jeu_queue, drives the output register
module jeu_back #(
  parameter int POSITION_BITS = jeu_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [jeu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [jeu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  jeu_pkg::item_t                     head,
  input  jeu_pkg::qstat_t                    stat,
  output logic                               pop,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [23:0]                        m_axis_tdata,  // out_byte, out_position
  output logic                               m_axis_tlast   // done_res
);

  localparam int CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

  typedef enum logic [2:0] {S_LOAD, S_RUN, S_SEQ, S_ESC2, S_TERM} state_t;

  state_t                     state, state_next;
  jeu_pkg::byte_t             q [jeu_pkg::WIN_SLOTS];
  jeu_pkg::byte_t             q_next [jeu_pkg::WIN_SLOTS];
  logic [2:0]                 n, n_next;
  logic [2:0]                 idx, idx_next;
  logic [1:0]                 hc, hc_next;
  logic                       fin, fin_next;
  logic                       stopped, stopped_next;
  logic [POSITION_BITS-1:0]   wp, wp_next;
  logic [1:0]                 rem, rem_next;
  logic [15:0]                start_pos, start_pos_next;
  logic [15:0]                cap, cap_next;
  logic                       out_valid, out_valid_next;
  logic [7:0]                 out_byte, out_byte_next;
  logic [15:0]                out_pos, out_pos_next;
  logic                       out_done, out_done_next;

  // decode of the byte under examination
  jeu_pkg::byte_t cur;
  logic [CW-1:0]  wp_ext;
  logic [CW-1:0]  cap_ext;
  logic           cap_hit;
  logic [2:0]     len;
  logic [2:0]     need;
  logic [2:0]     avail;
  logic [2:0]     lim;
  logic           ok;
  logic           fit;
  logic           emit_ok;

  // sequencer controls
  logic           emit;
  logic [7:0]     emit_byte;
  logic           emit_done;
  logic           loop_end;
  logic           hold;
  logic           load_req;
  logic [1:0]     hc_n;

  assign cur     = q[idx[1:0]];
  assign wp_ext  = CW'(wp);
  assign cap_ext = CW'(cap);
  assign cap_hit = (wp_ext + CW'(2)) >= cap_ext;
  assign emit_ok = !out_valid || m_axis_tready;
  assign need    = len - 3'd1;
  assign avail   = n - idx - 3'd1;
  assign lim     = (avail < need) ? avail : need;
  assign fit     = (wp_ext + CW'(len)) < cap_ext;

  always_comb begin
    unique case (cur.kind)
      jeu_pkg::K_LEAD2: len = 3'd2;
      jeu_pkg::K_LEAD3: len = 3'd3;
      jeu_pkg::K_LEAD4: len = 3'd4;
      default:          len = 3'd1;
    endcase
  end

  // continuation check over the bytes present after the lead
  always_comb begin
    logic [2:0] sel;
    ok = 1'b1;
    for (int k = 1; k < jeu_pkg::WIN_SLOTS; k++) begin
      sel = idx + 3'(k);
      if (3'(k) <= lim && !q[sel[1:0]].cont) begin
        ok = 1'b0;
      end
    end
  end

  always_comb begin
    logic [2:0] sel;
    state_next     = state;
    n_next         = n;
    idx_next       = idx;
    hc_next        = hc;
    fin_next       = fin;
    stopped_next   = stopped;
    wp_next        = wp;
    rem_next       = rem;
    start_pos_next = start_pos;
    cap_next       = cap;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    out_pos_next   = out_pos;
    out_done_next  = out_done;
    for (int k = 0; k < jeu_pkg::WIN_SLOTS; k++) begin
      q_next[k] = q[k];
    end
    emit      = 1'b0;
    emit_byte = jeu_pkg::CH_NUL;
    emit_done = 1'b0;
    loop_end  = 1'b0;
    hold      = 1'b0;
    load_req  = 1'b0;
    hc_n      = hc;
    pop       = 1'b0;
    sel       = 3'd0;

    unique case (state)
      S_LOAD: begin
        load_req = 1'b1;
      end
      S_RUN: begin
        if (idx >= n) begin
          loop_end = 1'b1;
        end else if (stopped || cap_hit) begin
          stopped_next = 1'b1;
          loop_end     = 1'b1;
        end else begin
          unique case (cur.kind)
            jeu_pkg::K_PASS: begin
              if (emit_ok) begin
                emit      = 1'b1;
                emit_byte = cur.data;
                idx_next  = idx + 3'd1;
              end
            end
            jeu_pkg::K_ESC: begin
              if (emit_ok) begin
                emit       = 1'b1;
                emit_byte  = jeu_pkg::CH_BSLASH;
                state_next = S_ESC2;
              end
            end
            jeu_pkg::K_LEAD2, jeu_pkg::K_LEAD3, jeu_pkg::K_LEAD4: begin
              if (ok && avail < need && !fin) begin
                loop_end = 1'b1;
                hold     = 1'b1;
              end else if (ok && avail >= need && fit) begin
                if (emit_ok) begin
                  emit       = 1'b1;
                  emit_byte  = cur.data;
                  idx_next   = idx + 3'd1;
                  rem_next   = need[1:0];
                  state_next = S_SEQ;
                end
              end else if (emit_ok) begin
                emit      = 1'b1;
                emit_byte = jeu_pkg::CH_QMARK;
                idx_next  = idx + 3'd1;
              end
            end
            default: begin
              if (emit_ok) begin
                emit      = 1'b1;
                emit_byte = jeu_pkg::CH_QMARK;
                idx_next  = idx + 3'd1;
              end
            end
          endcase
        end
      end
      S_SEQ: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = cur.data;
          idx_next  = idx + 3'd1;
          rem_next  = rem - 2'd1;
          if (rem == 2'd1) begin
            state_next = S_RUN;
          end
        end
      end
      S_ESC2: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_byte  = jeu_pkg::esc_char(cur.data);
          idx_next   = idx + 3'd1;
          state_next = S_RUN;
        end
      end
      S_TERM: begin
        if (emit_ok) begin
          emit         = 1'b1;
          emit_byte    = jeu_pkg::CH_NUL;
          emit_done    = 1'b1;
          wp_next      = POSITION_BITS'(start_pos);
          hc_next      = 2'd0;
          stopped_next = 1'b0;
          state_next   = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    // close the item: on an end item go to the terminator, else keep an incomplete sequence at the window base
    if (loop_end) begin
      if (fin) begin
        hc_next    = 2'd0;
        state_next = S_TERM;
      end else begin
        hc_n    = hold ? 2'(n - idx) : 2'd0;
        hc_next = hc_n;
        for (int k = 0; k < jeu_pkg::WIN_SLOTS; k++) begin
          sel = idx + 3'(k);
          if (3'(k) < {1'b0, hc_n}) begin
            q_next[k] = q[sel[1:0]];
          end
        end
        load_req   = 1'b1;
        state_next = S_LOAD;
      end
    end

    // append the next queued byte behind the held ones
    if (load_req && stat.nonempty) begin
      pop        = 1'b1;
      if (head.has) begin
        q_next[hc_n] = head.b;
      end
      n_next     = {1'b0, hc_n} + {2'b00, head.has};
      idx_next   = 3'd0;
      fin_next   = head.fin;
      state_next = S_RUN;
    end

    if (emit) begin
      out_valid_next = 1'b1;
      out_byte_next  = emit_byte;
      out_pos_next   = wp_ext[15:0];
      out_done_next  = emit_done;
      if (!emit_done) begin
        wp_next = wp + POSITION_BITS'(1);
      end
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        jeu_pkg::REG_START_POSITION: begin
          start_pos_next = cfg_data;
          wp_next        = POSITION_BITS'(cfg_data);
        end
        jeu_pkg::REG_BUFFER_CAPACITY: begin
          cap_next = cfg_data;
        end
        default: begin
          cap_next = cap;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      n         <= 3'd0;
      idx       <= 3'd0;
      hc        <= 2'd0;
      fin       <= 1'b0;
      stopped   <= 1'b0;
      wp        <= POSITION_BITS'(jeu_pkg::START_RESET);
      rem       <= 2'd0;
      start_pos <= jeu_pkg::START_RESET;
      cap       <= jeu_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      n         <= n_next;
      idx       <= idx_next;
      hc        <= hc_next;
      fin       <= fin_next;
      stopped   <= stopped_next;
      wp        <= wp_next;
      rem       <= rem_next;
      start_pos <= start_pos_next;
      cap       <= cap_next;
      out_valid <= out_valid_next;
    end
    for (int k = 0; k < jeu_pkg::WIN_SLOTS; k++) begin
      q[k] <= q_next[k];
    end
    out_byte <= out_byte_next;
    out_pos  <= out_pos_next;
    out_done <= out_done_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_pos, out_byte};
  assign m_axis_tlast  = out_done;

  // the window never holds more than four bytes and the cursor stays inside it
  a_window: assert property (@(posedge clk) disable iff (rst)
    (n <= 3'd4) && (idx <= n))
    else $error("window cursor out of range");

  // a multi-byte copy always has bytes left to emit
  a_seq_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEQ) |-> (rem != 2'd0))
    else $error("sequence copy with nothing left");

  // once stopped only the terminator is written
  a_stopped: assert property (@(posedge clk) disable iff (rst)
    (stopped && emit) |-> (state == S_TERM))
    else $error("byte written after capacity stop");

  // the terminator ends the run with no held bytes and no stop
  a_term_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERM && emit_ok && !cfg_we) |=> (hc == 2'd0 && !stopped && m_axis_tlast))
    else $error("run state not cleared after terminator");

endmodule

// File: rtl/json_escape_utf8_filter.sv
// json_escape_utf8_filter: top level of the json string escaper with utf-8 validation
// depends on jeu_pkg, jeu_front, jeu_queue and jeu_back
//
// Turns a byte stream into the body of a JSON string. Each input item carries a
// data byte (tdata), a has-byte flag (tuser) and an end-of-data mark (tlast). Each
// output item is one written byte with its buffer position; tlast marks the NUL
// terminator that closes a run. Quote and backslash get a backslash, newline, CR
// and tab become \n, \r, \t, other control bytes become '?', ASCII passes, and a
// UTF-8 sequence passes whole only when its lead is valid, its continuation
// bytes are all there and it fits below buffer_capacity; otherwise the lead
// becomes '?' and the bytes behind it are looked at again. Writing stops for the
// rest of the run once position+2 reaches the capacity. The back-end sequencer
// writes one output byte per cycle while the output register can take it, and
// closes each item in a step that writes nothing before it loads the next. A
// four-entry queue lets input keep flowing while the sequencer or the output
// side stalls; the output register holds one byte, and the sequencer waits
// while that byte is pending and not being taken.
module json_escape_utf8_filter #(
  parameter int POSITION_BITS = jeu_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: 0 start_position, 1 buffer_capacity
  input  logic                               cfg_we,
  input  logic [jeu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [jeu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // in_byte
  input  logic                               s_axis_tuser,   // has_byte
  input  logic                               s_axis_tlast,   // is_final
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [23:0]                        m_axis_tdata,   // out_byte, out_position
  output logic                               m_axis_tlast    // done_res
);

  // classified item path from front to back
  logic             push;
  jeu_pkg::item_t   push_item;
  logic             pop;
  jeu_pkg::item_t   head;
  jeu_pkg::qstat_t  stat;

  // front: accept and classify
  jeu_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .stat          (stat),
    .push          (push),
    .push_item     (push_item)
  );

  // queue decouples intake from the sequencer
  jeu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // back: escape, utf-8 checks, capacity stop, positions and terminator
  jeu_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: dv/json_escape_utf8_filter_test.sv
// json_escape_utf8_filter_test: self-checking testbench for the json string escaper
// depends on jeu_pkg and json_escape_utf8_filter; predicts every written byte and
// its buffer position in-line and checks each output item against that prediction
module json_escape_utf8_filter_test;

  // idle cycles allowed after the last written byte, covers items that write nothing
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int RANDOM_ITEMS  = 120;
  localparam int CALM_ITEMS    = 25;

  // how a byte list ends its run
  localparam int RUN_OPEN          = 0;
  localparam int RUN_CLOSE_ON_BYTE = 1;
  localparam int RUN_CLOSE_AFTER   = 2;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [jeu_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [jeu_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;   // in_byte
  logic s_axis_tuser;         // has_byte
  logic s_axis_tlast;         // is_final
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;  // out_byte, out_position
  logic m_axis_tlast;         // done_res

  json_escape_utf8_filter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // one predicted byte of the destination buffer
  typedef struct {
    logic [7:0]  value;
    logic [15:0] pos;
    logic        term;
  } written_t;

  written_t written_q[$];
  logic [7:0] byte_list[$];

  // mirror of the escaper state and its registers
  logic [15:0] start_pos;
  logic [15:0] capacity;
  logic [15:0] wr_pos;
  logic [7:0]  held [3];
  int          held_cnt;
  bit          stopped;

  int  fail_count = 0;
  int  items_sent = 0;
  bit  quiet = 0;
  int  send_idle_pct = 25;
  int  recv_stall_pct = 25;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("json_escape_utf8_filter: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void write_out(input logic [7:0] v, input bit term);
    written_t w;
    w.value = v;
    w.pos = wr_pos;
    w.term = term;
    written_q.push_back(w);
    // the terminator does not advance the position
    if (!term) wr_pos = wr_pos + 16'd1;
  endfunction

  function automatic int seq_len(input logic [7:0] v);
    if (v >= jeu_pkg::LEAD2_LO && v <= jeu_pkg::LEAD2_HI) return 2;
    if (v >= jeu_pkg::LEAD3_LO && v <= jeu_pkg::LEAD3_HI) return 3;
    if (v >= jeu_pkg::LEAD4_LO && v <= jeu_pkg::LEAD4_HI) return 4;
    return 0;
  endfunction

  function automatic bit is_cont(input logic [7:0] v);
    return v >= jeu_pkg::CONT_LO && v <= jeu_pkg::CONT_HI;
  endfunction

  // works out the bytes one accepted item writes into the buffer
  function automatic void escape_item(input logic [7:0] b, input bit has, input bit fin);
    logic [7:0] win [4];
    logic [7:0] v;
    int n, idx, k, len, avail, lim;
    bit ok, holding;
    n = 0;
    idx = 0;
    holding = 0;
    // window: held partial sequence, then the new byte
    for (k = 0; k < held_cnt; k++) begin
      win[n] = held[k];
      n++;
    end
    if (has) begin
      win[n] = b;
      n++;
    end
    while (idx < n) begin
      // capacity check before each byte, sticky for the rest of the run
      if (stopped || int'(wr_pos) + 2 >= int'(capacity)) begin
        stopped = 1;
        break;
      end
      v = win[idx];
      if (v == jeu_pkg::CH_QUOTE || v == jeu_pkg::CH_BSLASH) begin
        write_out(jeu_pkg::CH_BSLASH, 0);
        write_out(v, 0);
        idx++;
      end else if (v == jeu_pkg::CH_LF || v == jeu_pkg::CH_CR || v == jeu_pkg::CH_TAB) begin
        write_out(jeu_pkg::CH_BSLASH, 0);
        write_out(v == jeu_pkg::CH_LF ? jeu_pkg::CH_LOW_N :
                  v == jeu_pkg::CH_CR ? jeu_pkg::CH_LOW_R : jeu_pkg::CH_LOW_T, 0);
        idx++;
      end else if (v < jeu_pkg::CTRL_LIMIT) begin
        write_out(jeu_pkg::CH_QMARK, 0);
        idx++;
      end else if (v < jeu_pkg::ASCII_LIMIT) begin
        write_out(v, 0);
        idx++;
      end else begin
        len = seq_len(v);
        if (len == 0) begin
          // stray continuation or invalid lead
          write_out(jeu_pkg::CH_QMARK, 0);
          idx++;
        end else begin
          avail = n - idx - 1;
          lim = avail < len - 1 ? avail : len - 1;
          ok = 1;
          for (k = 1; k <= lim; k++) begin
            if (!is_cont(win[idx + k])) ok = 0;
          end
          if (ok && avail < len - 1 && !fin) begin
            // sequence so far is good but incomplete, keep it for later
            held_cnt = n - idx;
            for (k = 0; k < held_cnt; k++) begin
              held[k] = win[idx + k];
            end
            holding = 1;
            break;
          end
          if (ok && avail >= len - 1 && int'(wr_pos) + len < int'(capacity)) begin
            for (k = 0; k < len; k++) begin
              write_out(win[idx + k], 0);
            end
            idx += len;
          end else begin
            // lead becomes '?', the bytes behind it are looked at again
            write_out(jeu_pkg::CH_QMARK, 0);
            idx++;
          end
        end
      end
    end
    if (!holding) held_cnt = 0;
    if (fin) begin
      // terminator goes out even when stopped, then a fresh run starts
      write_out(jeu_pkg::CH_NUL, 1);
      wr_pos = start_pos;
      held_cnt = 0;
      stopped = 0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    written_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (written_q.size() == 0) begin
        $error("unexpected item: out_byte %02h out_position %0d done_res %0b",
               m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast);
        fail_count++;
      end else begin
        w = written_q.pop_front();
        if (m_axis_tdata[7:0] !== w.value) begin
          $error("out_byte: expected %02h, got %02h", w.value, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[23:8] !== w.pos) begin
          $error("out_position: expected %0d, got %0d", w.pos, m_axis_tdata[23:8]);
          fail_count++;
        end
        if (m_axis_tlast !== w.term) begin
          $error("done_res: expected %0b, got %0b", w.term, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // output side: random stall bursts, none once quiet
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < recv_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // sends one item; tvalid stays high afterwards unless a gap comes next
  task automatic send_item(input logic [7:0] b, input bit has, input bit fin);
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tdata <= b;
    s_axis_tuser <= has;
    s_axis_tlast <= fin;
    s_axis_tvalid <= 1'b1;
    escape_item(b, has, fin);
    do @(posedge clk); while (!s_axis_tready);
    if (has || fin) items_sent++;
  endtask

  task automatic send_list(input int close_mode);
    int k;
    for (k = 0; k < byte_list.size(); k++) begin
      // an empty item now and then, it must change nothing
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom_range(0, 255)), 0, 0);
      send_item(byte_list[k], 1, close_mode == RUN_CLOSE_ON_BYTE && k == byte_list.size() - 1);
    end
    if (close_mode == RUN_CLOSE_AFTER) send_item(8'($urandom_range(0, 255)), 0, 1);
  endtask

  // block idle: every written byte seen, plus time for items that write nothing
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (written_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jeu_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    // start_position also reloads the write position
    if (idx == jeu_pkg::REG_START_POSITION) begin
      start_pos = val;
      wr_pos = val;
    end else if (idx == jeu_pkg::REG_BUFFER_CAPACITY) begin
      capacity = val;
    end
  endtask

  task automatic configure(input logic [15:0] start, input logic [15:0] cap);
    settle();
    write_reg(jeu_pkg::REG_START_POSITION, start);
    write_reg(jeu_pkg::REG_BUFFER_CAPACITY, cap);
  endtask

  function automatic logic [7:0] lead_for(input int len);
    if (len == 2) return 8'($urandom_range(jeu_pkg::LEAD2_LO, jeu_pkg::LEAD2_HI));
    if (len == 3) return 8'($urandom_range(jeu_pkg::LEAD3_LO, jeu_pkg::LEAD3_HI));
    return 8'($urandom_range(jeu_pkg::LEAD4_LO, jeu_pkg::LEAD4_HI));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // mostly well-formed text and utf-8, with broken sequences and noise mixed in
  task automatic fill_random_bytes(input int count);
    int kind, len, k;
    byte_list = {};
    while (byte_list.size() < count) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        byte_list.push_back(8'($urandom_range(8'h20, 8'h7F)));
      end else if (kind < 8) begin
        case ($urandom_range(0, 4))
          0: byte_list.push_back(jeu_pkg::CH_QUOTE);
          1: byte_list.push_back(jeu_pkg::CH_BSLASH);
          2: byte_list.push_back(jeu_pkg::CH_LF);
          3: byte_list.push_back(jeu_pkg::CH_CR);
          default: byte_list.push_back(jeu_pkg::CH_TAB);
        endcase
      end else if (kind < 9) begin
        byte_list.push_back(8'($urandom_range(8'h00, 8'h1F)));
      end else if (kind < 15) begin
        len = $urandom_range(2, 4);
        byte_list.push_back(lead_for(len));
        for (k = 1; k < len; k++) begin
          byte_list.push_back(8'($urandom_range(jeu_pkg::CONT_LO, jeu_pkg::CONT_HI)));
        end
      end else if (kind < 18) begin
        // truncated sequence, sometimes cut by a byte that is no continuation
        len = $urandom_range(2, 4);
        byte_list.push_back(lead_for(len));
        repeat ($urandom_range(0, len - 2)) begin
          byte_list.push_back(8'($urandom_range(jeu_pkg::CONT_LO, jeu_pkg::CONT_HI)));
        end
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 1)) byte_list.push_back(8'($urandom_range(8'h00, 8'h7F)));
          else byte_list.push_back(8'($urandom_range(8'hC0, 8'hFF)));
        end
      end else begin
        byte_list.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_config();
    int start, cap, pick;
    pick = $urandom_range(0, 19);
    start = $urandom_range(0, 65535);
    if (pick < 5) begin
      cap = 65535;
    end else if (pick < 13) begin
      // capacity a little above the start, runs hit the limit
      cap = start + $urandom_range(0, 60);
      if (cap > 65535) cap = 65535;
    end else if (pick < 15) begin
      cap = $urandom_range(0, 65535);
    end else begin
      start = $urandom_range(0, 20);
      cap = start + $urandom_range(3, 40);
    end
    configure(16'(start), 16'(cap));
  endtask

  // ---------------------------------------------------------------- tests

  // each escape, control and ascii extremes, every utf-8 length, broken and
  // truncated sequences, an empty item and an end-only item flushing held bytes
  task automatic test_escapes_and_utf8();
    byte_list = '{8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF5,
                  8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h80, 8'h80, 8'hBF,
                  8'hE0, 8'h41, 8'hF0, 8'h90};
    send_list(RUN_OPEN);
    // held bytes survive an empty item, then the end flushes them as '?'
    send_item(8'hA5, 0, 0);
    send_item(8'h00, 0, 1);
  endtask

  task automatic test_register_extremes();
    // capacity zero: stopped at once, terminator still at the top position
    configure(16'hFFFF, 16'h0000);
    byte_list = '{8'h41};
    send_list(RUN_CLOSE_ON_BYTE);
    configure(16'h0000, 16'h0003);
    byte_list = '{8'h61, 8'h62, 8'h63};
    send_list(RUN_CLOSE_AFTER);
    // three-byte sequence that does not fit below capacity
    configure(16'd200, 16'd203);
    byte_list = '{8'hE2, 8'h82, 8'hAC};
    send_list(RUN_CLOSE_ON_BYTE);
    configure(16'h5555, 16'hAAAA);
    byte_list = '{8'hC3, 8'hA9, 8'h22, 8'h0A};
    send_list(RUN_CLOSE_AFTER);
    // four-byte sequence that just fits, then the limit
    configure(16'hAAA8, 16'hAAAD);
    byte_list = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7A};
    send_list(RUN_CLOSE_ON_BYTE);
    configure(jeu_pkg::START_RESET, jeu_pkg::CAP_RESET);
  endtask

  // lower capacity inside a run, then raise it: stopped must stay set
  task automatic test_capacity_change_mid_run();
    configure(16'd300, 16'hFFFF);
    byte_list = '{8'h61, 8'h62};
    send_list(RUN_OPEN);
    settle();
    write_reg(jeu_pkg::REG_BUFFER_CAPACITY, 16'd304);
    byte_list = '{8'h63, 8'h64, 8'h65};
    send_list(RUN_OPEN);
    settle();
    write_reg(jeu_pkg::REG_BUFFER_CAPACITY, 16'hFFFF);
    byte_list = '{8'h66};
    send_list(RUN_CLOSE_AFTER);
  endtask

  // new start position inside a run moves the write position, held bytes stay
  task automatic test_start_change_mid_run();
    configure(16'd500, 16'hFFFF);
    byte_list = '{8'h61, 8'hF0};
    send_list(RUN_OPEN);
    settle();
    write_reg(jeu_pkg::REG_START_POSITION, 16'd1000);
    byte_list = '{8'h9F, 8'h98, 8'h80};
    send_list(RUN_CLOSE_ON_BYTE);
    byte_list = '{8'h22};
    send_list(RUN_CLOSE_AFTER);
  endtask

  task automatic test_random_runs();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) == 0) random_config();
      // idling rates change per run, including runs with none
      send_idle_pct = pick_pct();
      recv_stall_pct = pick_pct();
      fill_random_bytes($urandom_range(1, 20));
      send_list($urandom_range(0, 1) ? RUN_CLOSE_ON_BYTE : RUN_CLOSE_AFTER);
    end
  endtask

  // back-to-back traffic on both sides to close the run
  task automatic test_streaming_without_idle();
    int goal;
    quiet = 1;
    random_config();
    goal = items_sent + CALM_ITEMS;
    while (items_sent < goal) begin
      fill_random_bytes($urandom_range(4, 16));
      send_list($urandom_range(0, 1) ? RUN_CLOSE_ON_BYTE : RUN_CLOSE_AFTER);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int waited;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= jeu_pkg::REG_START_POSITION;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    start_pos = jeu_pkg::START_RESET;
    capacity = jeu_pkg::CAP_RESET;
    wr_pos = jeu_pkg::START_RESET;
    held_cnt = 0;
    stopped = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_escapes_and_utf8();
    test_register_extremes();
    test_capacity_change_mid_run();
    test_start_change_mid_run();
    test_random_runs();
    test_streaming_without_idle();

    // drain, then leave room for anything extra the block might still send
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (written_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (written_q.size() != 0) begin
      $error("%0d written bytes never arrived", written_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("json_escape_utf8_filter: match");
    end else begin
      $display("json_escape_utf8_filter: mismatch");
    end
    $finish;
  end

endmodule
